/* hdl/bfi_pkg.sv */
// bfi_pkg: shared types and constants of the bitcell to flux interval block
// used by every module under hdl; depends on nothing

package bfi_pkg;

    // field widths
    localparam int CELL_TIME_W = 16;
    localparam int SPEED_W     = 16;
    localparam int IVL_W       = 23;
    localparam int DUR_W       = IVL_W + 1;
    localparam int PROD_W      = CELL_TIME_W + SPEED_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;

    // largest interval, the running sum saturates here
    localparam logic [IVL_W-1:0] IVL_MAX = {IVL_W{1'b1}};

    // register reset values
    localparam logic [CELL_TIME_W-1:0] CELL_TIME_RST    = 16'd2000;
    localparam logic [IVL_W-1:0]       MAX_INTERVAL_RST = 23'd1000000;

    // parameter defaults
    localparam logic [SPEED_W-1:0] SPEED_UNIT_DEF = 16'd1000;
    localparam logic [SPEED_W-1:0] WEAK_MARK_DEF  = 16'd65534;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 2'd1;

    // one classified cell on its way to the back end
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic             flux_bit;
        logic             index_mark;
    } bfi_item_t;

endpackage

/* hdl/bitcell_to_flux_interval.sv */
// bitcell_to_flux_interval: top level, configuration registers and wiring
// depends on bfi_pkg, bfi_front, bfi_queue, bfi_back
//
//   channel   direction   handshake             payload
//   cell      in          cell_valid/stall      cell_bit, cell_speed, at_index
//   flux      out         flux_valid/stall      interval_ns, index_seen, index_offset_ns
//   cfg       in          cfg_valid/ready       cfg_index, cfg_data
//
// one cell per cycle sustained while credits remain; a cell reaches the back end through the
// multiply and constant-divide pipeline in the front end
// the queue plus pipeline holds eight cells; the front stalls when all credits are out
// reset clears the interval state, the queue and the result valid at once
// cfg is always ready; writes beyond the two registers are dropped

module bitcell_to_flux_interval #(
    parameter logic [15:0] SPEED_UNIT = bfi_pkg::SPEED_UNIT_DEF,
    parameter logic [15:0] WEAK_MARK  = bfi_pkg::WEAK_MARK_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cell_valid,
    output logic                              cell_stall,
    input  logic                              cell_bit,
    input  logic [bfi_pkg::SPEED_W-1:0]       cell_speed,
    input  logic                              at_index,
    output logic                              flux_valid,
    input  logic                              flux_stall,
    output logic [bfi_pkg::IVL_W-1:0]         interval_ns,
    output logic                              index_seen,
    output logic [bfi_pkg::IVL_W-1:0]         index_offset_ns,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfi_pkg::*;

    logic [CELL_TIME_W-1:0] cell_time_reg;
    logic [IVL_W-1:0]       max_ivl_reg;

    logic      push;
    bfi_item_t push_item;
    logic      pop;
    logic      empty;
    bfi_item_t head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_time_reg <= CELL_TIME_RST;
            max_ivl_reg   <= MAX_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CELL_TIME:    cell_time_reg <= cfg_data[CELL_TIME_W-1:0];
                CFG_MAX_INTERVAL: max_ivl_reg   <= cfg_data[IVL_W-1:0];
                default:          ;
            endcase
        end
    end

    bfi_front #(
        .SPEED_UNIT (SPEED_UNIT),
        .WEAK_MARK  (WEAK_MARK)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_bit   (cell_bit),
        .cell_speed (cell_speed),
        .at_index   (at_index),
        .cell_time  (cell_time_reg),
        .pop        (pop),
        .push       (push),
        .push_item  (push_item)
    );

    bfi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    bfi_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .head            (head),
        .pop             (pop),
        .max_interval    (max_ivl_reg),
        .flux_valid      (flux_valid),
        .flux_stall      (flux_stall),
        .interval_ns     (interval_ns),
        .index_seen      (index_seen),
        .index_offset_ns (index_offset_ns)
    );

endmodule

/* hdl/bfi_front.sv */
// bfi_front: accepts bitcells, maps weak speed and works out each cell's duration
// depends on bfi_pkg; feeds bfi_queue, holds the credit count for it

module bfi_front #(
    parameter logic [15:0] SPEED_UNIT = bfi_pkg::SPEED_UNIT_DEF,
    parameter logic [15:0] WEAK_MARK  = bfi_pkg::WEAK_MARK_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cell_valid,
    output logic                               cell_stall,
    input  logic                               cell_bit,
    input  logic [bfi_pkg::SPEED_W-1:0]        cell_speed,
    input  logic                               at_index,
    input  logic [bfi_pkg::CELL_TIME_W-1:0]    cell_time,
    input  logic                               pop,
    output logic                               push,
    output bfi_pkg::bfi_item_t                 push_item
);
    import bfi_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // reciprocal of the speed unit scaled by 2^32; error of the estimate is at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(SPEED_UNIT));

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              accept;
    logic [SPEED_W-1:0] eff_speed;

    // stage valids and markers
    logic [3:0] vld_reg;
    logic [3:0] fbit_reg;
    logic [3:0] fidx_reg;

    logic [PROD_W-1:0] prod1_reg, prod2_reg, prod3_reg, prod4_reg;
    logic [47:0]       plo_reg;
    logic [48:0]       phi_reg;
    logic [31:0]       qest3_reg, qest4_reg;
    logic [47:0]       qd4_reg;

    logic [64:0]       est_sum;
    logic [32:0]       rem;
    logic [31:0]       quot;

    // credit count covers pipeline and queue, so the queue never overflows
    assign cell_stall = (cnt_reg >= CNT_W'(QUEUE_DEPTH));
    assign accept     = cell_valid && !cell_stall;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(accept) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= {vld_reg[2:0], accept};
        end
    end

    // weak marker counts as nominal speed
    assign eff_speed = (cell_speed == WEAK_MARK) ? SPEED_UNIT : cell_speed;

    // quotient estimate from the registered partial products
    assign est_sum = {17'd0, plo_reg} + {phi_reg, 16'd0};

    // one correction step after the estimate
    assign rem  = 33'(prod4_reg) - qd4_reg[32:0];
    assign quot = qest4_reg + 32'(rem >= 33'(SPEED_UNIT));

    // duration pipeline: multiply, split reciprocal product, estimate, back multiply
    always_ff @(posedge clk)
    begin
        fbit_reg  <= {fbit_reg[2:0], cell_bit};
        fidx_reg  <= {fidx_reg[2:0], at_index};
        prod1_reg <= PROD_W'(cell_time) * PROD_W'(eff_speed);
        prod2_reg <= prod1_reg;
        plo_reg   <= 48'(prod1_reg) * 48'(RECIP[15:0]);
        phi_reg   <= 49'(prod1_reg) * 49'(RECIP[32:16]);
        prod3_reg <= prod2_reg;
        qest3_reg <= est_sum[63:32];
        prod4_reg <= prod3_reg;
        qest4_reg <= qest3_reg;
        qd4_reg   <= 48'(qest3_reg) * 48'(SPEED_UNIT);
    end

    // anything at or above 2^23 saturates the sum anyway
    assign push                 = vld_reg[3];
    assign push_item.dur        = (|quot[31:IVL_W]) ? DUR_W'(1) << IVL_W
                                                    : DUR_W'(quot[IVL_W-1:0]);
    assign push_item.flux_bit   = fbit_reg[3];
    assign push_item.index_mark = fidx_reg[3];

endmodule

/* hdl/bfi_queue.sv */
// bfi_queue: short first-in first-out queue between front and back
// depends on bfi_pkg for the item type and depth

module bfi_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bfi_pkg::bfi_item_t  push_item,
    input  logic                pop,
    output logic                empty,
    output bfi_pkg::bfi_item_t  head
);
    import bfi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bfi_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

endmodule

/* hdl/bfi_back.sv */
// bfi_back: running interval, index offset and flux result register
// depends on bfi_pkg; pulls classified cells from bfi_queue

module bfi_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           empty,
    input  bfi_pkg::bfi_item_t             head,
    output logic                           pop,
    input  logic [bfi_pkg::IVL_W-1:0]      max_interval,
    output logic                           flux_valid,
    input  logic                           flux_stall,
    output logic [bfi_pkg::IVL_W-1:0]      interval_ns,
    output logic                           index_seen,
    output logic [bfi_pkg::IVL_W-1:0]      index_offset_ns
);
    import bfi_pkg::*;

    logic [IVL_W-1:0] run_reg, run_next;
    logic             pend_reg, pend_next;
    logic [IVL_W-1:0] ofs_reg, ofs_next;

    logic             out_vld_reg, out_vld_next;
    logic [IVL_W-1:0] out_ivl_reg;
    logic             out_seen_reg;
    logic [IVL_W-1:0] out_ofs_reg;

    logic [DUR_W:0]   sum;
    logic [IVL_W-1:0] sat;
    logic             emit;
    logic             out_free;
    logic             idx_pend;
    logic [IVL_W-1:0] idx_ofs;

    // offset is taken before this cell's own time is added
    assign idx_pend = pend_reg | head.index_mark;
    assign idx_ofs  = head.index_mark ? run_reg : ofs_reg;

    // saturating add of the cell duration
    assign sum  = (DUR_W+1)'(run_reg) + (DUR_W+1)'(head.dur);
    assign sat  = (sum > (DUR_W+1)'(IVL_MAX)) ? IVL_MAX : sum[IVL_W-1:0];
    assign emit = head.flux_bit || (sat >= max_interval);

    // a cell that emits needs the result register free
    assign out_free = !out_vld_reg || !flux_stall;
    assign pop      = !empty && (!emit || out_free);

    always_comb
    begin
        run_next     = run_reg;
        pend_next    = pend_reg;
        ofs_next     = ofs_reg;
        out_vld_next = out_vld_reg && flux_stall;
        if (pop)
        begin
            if (emit)
            begin
                run_next     = '0;
                pend_next    = 1'b0;
                ofs_next     = '0;
                out_vld_next = 1'b1;
            end
            else
            begin
                run_next  = sat;
                pend_next = idx_pend;
                ofs_next  = idx_ofs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            pend_reg    <= 1'b0;
            ofs_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            pend_reg    <= pend_next;
            ofs_reg     <= ofs_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_ivl_reg  <= sat;
            out_seen_reg <= idx_pend;
            out_ofs_reg  <= idx_pend ? idx_ofs : '0;
        end
    end

    assign flux_valid      = out_vld_reg;
    assign interval_ns     = out_ivl_reg;
    assign index_seen      = out_seen_reg;
    assign index_offset_ns = out_ofs_reg;

endmodule

/* tb/tb_bitcell_to_flux_interval.sv */
// tb_bitcell_to_flux_interval: self-checking bench for the bitcell to flux interval block
// depends on bfi_pkg and bitcell_to_flux_interval; a local timing model predicts every flux result
// directed table first, then fixed and randomized register settings with random cell streams

module tb_bitcell_to_flux_interval;

    timeunit 1ns;
    timeprecision 1ps;

    import bfi_pkg::*;

    localparam int DIR_N           = 28;
    localparam int PHASES          = 6;
    localparam int CELLS_PER_PHASE = 188;
    localparam int DRAIN_CYCLES    = 24;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {ROW_CELL, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_FLUX} row_chk_t;

    typedef struct packed {
        logic [IVL_W-1:0] ivl;
        logic             seen;
        logic [IVL_W-1:0] off;
    } flux_t;

    // one directed step: a cell, or a register write
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [IVL_W-1:0]     val;
        logic                 flux;
        logic                 ix;
        row_chk_t             chk;
        logic [IVL_W-1:0]     e_ivl;
        logic                 e_seen;
        logic [IVL_W-1:0]     e_off;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cell_valid;
    logic                  cell_stall;
    logic                  cell_bit;
    logic [SPEED_W-1:0]    cell_speed;
    logic                  at_index;
    logic                  flux_valid;
    logic                  flux_stall;
    logic [IVL_W-1:0]      interval_ns;
    logic                  index_seen;
    logic [IVL_W-1:0]      index_offset_ns;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // timing model state and register shadows
    logic [CELL_TIME_W-1:0] cell_time_sh;
    logic [IVL_W-1:0]       max_interval_sh;
    logic [IVL_W-1:0]       acc_interval;
    logic                   idx_armed;
    logic [IVL_W-1:0]       idx_offset;

    flux_t    flux_expected[$];
    dir_row_t dir_rows [DIR_N];

    int err_count;
    int cells_sent;
    int flux_checked;
    int forced_count;
    int cfg_writes;
    int stall_left;
    bit gaps_on;

    bitcell_to_flux_interval u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cell_valid      (cell_valid),
        .cell_stall      (cell_stall),
        .cell_bit        (cell_bit),
        .cell_speed      (cell_speed),
        .at_index        (at_index),
        .flux_valid      (flux_valid),
        .flux_stall      (flux_stall),
        .interval_ns     (interval_ns),
        .index_seen      (index_seen),
        .index_offset_ns (index_offset_ns),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [IVL_W-1:0] got,
                                   input logic [IVL_W-1:0] want);
        err_count++;
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // add one cell to the running interval, return 1 when it closes a flux result
    function automatic bit predict_flux(input logic b, input logic [SPEED_W-1:0] s,
                                       input logic ix, output flux_t res);
        longint unsigned eff;
        longint unsigned sum;
        eff = (s == WEAK_MARK_DEF) ? SPEED_UNIT_DEF : s;
        // the offset is taken before this cell's own time
        if (ix)
        begin
            idx_armed  = 1'b1;
            idx_offset = acc_interval;
        end
        sum = acc_interval + (cell_time_sh * eff) / SPEED_UNIT_DEF;
        if (sum > IVL_MAX)
            sum = IVL_MAX;
        acc_interval = sum[IVL_W-1:0];
        res = '0;
        if (!b && acc_interval < max_interval_sh)
            return 1'b0;
        if (!b)
            forced_count++;
        res.ivl      = acc_interval;
        res.seen     = idx_armed;
        res.off      = idx_armed ? idx_offset : '0;
        acc_interval = '0;
        idx_armed    = 1'b0;
        idx_offset   = '0;
        return 1'b1;
    endfunction

    task automatic cell_pause(input int n);
        cell_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // one cell transfer, then update the model
    task automatic send_cell(input logic b, input logic [SPEED_W-1:0] s, input logic ix,
                             output bit emitted, output flux_t res);
        cell_valid <= 1'b1;
        cell_bit   <= b;
        cell_speed <= s;
        at_index   <= ix;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        emitted = predict_flux(b, s, ix, res);
        cells_sent++;
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
        while (flux_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (sel == CFG_CELL_TIME)
            cell_time_sh = data[CELL_TIME_W-1:0];
        else if (sel == CFG_MAX_INTERVAL)
            max_interval_sh = data[IVL_W-1:0];
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // flux checker and random stall bursts
    always @(posedge clk)
    begin
        flux_t want;
        if (rst_n && flux_valid && !flux_stall)
        begin
            if (flux_expected.size() == 0)
                report_mismatch("flux transfer with nothing expected, interval_ns", interval_ns, '0);
            else
            begin
                want = flux_expected.pop_front();
                if (interval_ns !== want.ivl)
                    report_mismatch("interval_ns", interval_ns, want.ivl);
                if (index_seen !== want.seen)
                    report_mismatch("index_seen", {22'd0, index_seen}, {22'd0, want.seen});
                if (index_offset_ns !== want.off)
                    report_mismatch("index_offset_ns", index_offset_ns, want.off);
                flux_checked++;
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            flux_stall <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            flux_stall <= 1'b1;
        end
        else
            flux_stall <= 1'b0;
    end

    initial
    begin
        bit                     emitted;
        flux_t                  res;
        logic [CELL_TIME_W-1:0] ct;
        logic [IVL_W-1:0]       mx;
        logic [SPEED_W-1:0]     spd;
        int                     bit_pct;

        err_count       = 0;
        cells_sent      = 0;
        flux_checked    = 0;
        forced_count    = 0;
        cfg_writes      = 0;
        stall_left      = 0;
        gaps_on         = 1'b1;
        cell_time_sh    = CELL_TIME_RST;
        max_interval_sh = MAX_INTERVAL_RST;
        acc_interval    = '0;
        idx_armed       = 1'b0;
        idx_offset      = '0;

        rst_n      <= 1'b0;
        cell_valid <= 1'b0;
        cell_bit   <= 1'b0;
        cell_speed <= '0;
        at_index   <= 1'b0;
        flux_stall <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_CELL_TIME;
        cfg_data   <= '0;

        dir_rows = '{
            // reset settings: 2000 ns per cell, forced result at 1 ms
            '{ROW_CELL, CFG_CELL_TIME, 23'd1000, 1'b1, 1'b0, CHK_FLUX, 23'd2000, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd1000, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            // weak cell counts as nominal; index offset taken before its own time
            '{ROW_CELL, CFG_CELL_TIME, 23'(WEAK_MARK_DEF), 1'b0, 1'b1, CHK_NONE,
              23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd500, 1'b1, 1'b0, CHK_FLUX, 23'd5000, 1'b1, 23'd2000},
            '{ROW_CELL, CFG_CELL_TIME, 23'd0, 1'b1, 1'b0, CHK_FLUX, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b1, 1'b1, CHK_FLUX, 23'd131070, 1'b1, 23'd0},
            // second index before emission replaces the first offset
            '{ROW_CELL, CFG_CELL_TIME, 23'd65533, 1'b0, 1'b1, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd1000, 1'b0, 1'b1, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd1, 1'b1, 1'b0, CHK_FLUX, 23'd133068, 1'b1, 23'd131066},
            // eight slow zero cells cross the 1 ms threshold
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_FLUX, 23'd1048560, 1'b0, 23'd0},
            // all-ones data, cell time masked to 16 bits; spare indexes must be dropped
            '{ROW_CFG, CFG_CELL_TIME, 23'h7FFFFF, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CFG, CFG_MAX_INTERVAL, 23'h7FFFFF, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CFG, CFG_SPARE_A, 23'd0, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CFG, CFG_SPARE_B, 23'd1, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            // running interval saturates at full scale
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b0, CHK_PRED, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd65535, 1'b0, 1'b1, CHK_PRED, 23'd0, 1'b0, 23'd0},
            // zero threshold: every cell closes a result
            '{ROW_CFG, CFG_MAX_INTERVAL, 23'd0, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd0, 1'b0, 1'b0, CHK_FLUX, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd1, 1'b0, 1'b1, CHK_FLUX, 23'd65, 1'b1, 23'd0},
            '{ROW_CFG, CFG_CELL_TIME, 23'd1, 1'b0, 1'b0, CHK_NONE, 23'd0, 1'b0, 23'd0},
            '{ROW_CELL, CFG_CELL_TIME, 23'd999, 1'b0, 1'b0, CHK_FLUX, 23'd0, 1'b0, 23'd0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_N; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                cell_pause(0);
                write_reg(dir_rows[r].sel, dir_rows[r].val);
            end
            else
            begin
                send_cell(dir_rows[r].flux, dir_rows[r].val[SPEED_W-1:0], dir_rows[r].ix,
                          emitted, res);
                case (dir_rows[r].chk)
                    CHK_PRED:
                        if (emitted)
                            flux_expected.push_back(res);
                    CHK_FLUX:
                        flux_expected.push_back('{dir_rows[r].e_ivl, dir_rows[r].e_seen,
                                                  dir_rows[r].e_off});
                    default:
                        ;
                endcase
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            cell_pause(0);
            case (p)
                0:
                begin
                    ct      = CELL_TIME_RST;
                    mx      = MAX_INTERVAL_RST;
                    bit_pct = 40;
                end
                1:
                begin
                    ct      = 16'hFFFF;
                    mx      = IVL_MAX;
                    bit_pct = 10;
                end
                2:
                begin
                    ct      = 16'd1;
                    mx      = 23'd1;
                    bit_pct = 5;
                end
                3:
                begin
                    ct      = CELL_TIME_W'($urandom_range(1, 65535));
                    mx      = '0;
                    bit_pct = 50;
                end
                4:
                begin
                    ct      = CELL_TIME_W'($urandom_range(1, 4000));
                    mx      = IVL_W'(ct * $urandom_range(1, 16));
                    bit_pct = 8;
                end
                default:
                begin
                    ct      = CELL_TIME_W'($urandom_range(1, 65535));
                    mx      = IVL_W'($urandom_range(0, 8388607));
                    bit_pct = 3;
                end
            endcase
            write_reg(CFG_CELL_TIME, {7'd0, ct});
            write_reg(CFG_MAX_INTERVAL, mx);
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom_range(0, 8388607)));
            // no gaps in one middle phase and in the closing phase
            gaps_on = (p != 2) && (p != PHASES - 1);

            for (int i = 0; i < CELLS_PER_PHASE; i++)
            begin
                if (gaps_on && $urandom_range(0, 4) == 0)
                    cell_pause($urandom_range(1, 11));
                case ($urandom_range(0, 9))
                    0:       spd = WEAK_MARK_DEF;
                    1:       spd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    2, 3:    spd = SPEED_W'($urandom_range(0, 65535));
                    default: spd = SPEED_W'($urandom_range(SPEED_UNIT_DEF - 100,
                                                           SPEED_UNIT_DEF + 100));
                endcase
                send_cell($urandom_range(0, 99) < bit_pct, spd, $urandom_range(0, 15) == 0,
                          emitted, res);
                if (emitted)
                    flux_expected.push_back(res);
            end
        end

        // drain
        cell_pause(0);
        while (flux_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("cells sent: %0d over %0d register writes", cells_sent, cfg_writes);
        $display("flux results checked: %0d, of which %0d forced by the threshold",
                 flux_checked, forced_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
